/* rtl/mrwt_pkg.sv */
// Package of shared types for the Miller-Rabin witness test block.
package mrwt_pkg;

  // Sequencer states, one-hot coded
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SPLIT  = 9'b000000010,
    ST_REDUCE = 9'b000000100,
    ST_POW    = 9'b000001000,
    ST_MUL    = 9'b000010000,
    ST_CHECK  = 9'b000100000,
    ST_SQCHK  = 9'b001000000,
    ST_SQTEST = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_e;

  // Which product the shared modular multiplier is forming
  typedef enum logic [1:0] {
    OP_RES  = 2'd0,  // x * base
    OP_BASE = 2'd1,  // base * base
    OP_SQR  = 2'd2   // x * x in the squaring chain
  } mul_op_e;

endpackage

/* rtl/miller_rabin_witness_test.sv */
// Top level: one Miller-Rabin round with a bit-serial modular datapath.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+----------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | candidate_i, witness_i
//  out     | source    | out_valid_o / out_stall_i| probable_prime_o, bad_input_o
//
// One word is worked at a time; in_stall_o is high from acceptance until the
// result moves to the output register. A bad candidate goes straight to the
// result. Otherwise the sequencer splits n-1, reduces the witness mod n and
// forms each modular product in the shared double-and-add unit, one multiplier
// bit per cycle, for the exponent bits and for up to s-1 squarings; a run is
// slowest at s = 1. Reset clears the sequencer and the output valid. A stalled
// result holds in the output register while the next word runs.
module miller_rabin_witness_test #(
  parameter int WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] candidate_i,
  input  logic [31:0] witness_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        probable_prime_o,
  output logic        bad_input_o
);
  import mrwt_pkg::*;

  localparam int CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // Control registers
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Datapath registers
  logic [WIDTH-1:0] n_q, n_d;
  logic [WIDTH-1:0] w_q, w_d;
  logic [WIDTH-1:0] d_q, d_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] base_q, base_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] mb_q, mb_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  s_q, s_d;
  mul_op_e          op_q, op_d;
  logic             prime_q, prime_d;
  logic             bad_q, bad_d;
  logic             pp_out_q, pp_out_d;
  logic             bad_out_q, bad_out_d;

  // Input words cut or zero-extended to the datapath width
  logic [63:0]      cand_ext, wit_ext;
  logic [WIDTH-1:0] n_in, w_in;

  assign cand_ext = 64'(candidate_i);
  assign wit_ext  = 64'(witness_i);
  assign n_in     = cand_ext[WIDTH-1:0];
  assign w_in     = wit_ext[WIDTH-1:0];

  // Restoring reduction step: shift one witness bit into the remainder
  logic [WIDTH:0]   rem_t;
  logic [WIDTH-1:0] rem_next;

  assign rem_t    = {acc_q, w_q[WIDTH-1]};
  assign rem_next = (rem_t >= {1'b0, n_q}) ? WIDTH'(rem_t - {1'b0, n_q})
                                           : rem_t[WIDTH-1:0];

  // Double-and-add step: acc = 2*acc (+ a) mod n
  logic [WIDTH-1:0] mul_a;
  logic [WIDTH+1:0] mul_t, n1_ext, n2_ext;
  logic [WIDTH-1:0] mul_next;

  always_comb begin
    unique case (op_q)
      OP_BASE: mul_a = base_q;
      OP_RES,
      OP_SQR:  mul_a = x_q;
      default: mul_a = x_q;
    endcase
  end

  assign n1_ext = {2'b00, n_q};
  assign n2_ext = {1'b0, n_q, 1'b0};
  assign mul_t  = {1'b0, acc_q, 1'b0}
                + (mb_q[WIDTH-1] ? {2'b00, mul_a} : '0);

  always_comb begin
    priority if (mul_t >= n2_ext) begin
      mul_next = WIDTH'(mul_t - n2_ext);
    end else if (mul_t >= n1_ext) begin
      mul_next = WIDTH'(mul_t - n1_ext);
    end else begin
      mul_next = mul_t[WIDTH-1:0];
    end
  end

  logic [WIDTH-1:0] nm1;
  logic             x_is_one, x_is_nm1, cnt_last;

  assign nm1      = n_q - WIDTH'(1);
  assign x_is_one = (x_q == WIDTH'(1));
  assign x_is_nm1 = (x_q == nm1);
  assign cnt_last = (cnt_q == CntW'(WIDTH - 1));

  // Sequencer
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    w_d       = w_q;
    d_d       = d_q;
    x_d       = x_q;
    base_d    = base_q;
    acc_d     = acc_q;
    mb_d      = mb_q;
    cnt_d     = cnt_q;
    s_d       = s_q;
    op_d      = op_q;
    prime_d   = prime_q;
    bad_d     = bad_q;
    pp_out_d  = pp_out_q;
    bad_out_d = bad_out_q;

    // drop the output word once taken
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          n_d = n_in;
          w_d = w_in;
          d_d = n_in - WIDTH'(1);
          s_d = '0;
          if (n_in < WIDTH'(3) || !n_in[0]) begin
            prime_d = 1'b0;
            bad_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            bad_d   = 1'b0;
            state_d = ST_SPLIT;
          end
        end
      end

      // strip factors of two from n-1
      ST_SPLIT: begin
        if (!d_q[0]) begin
          d_d = d_q >> 1;
          s_d = s_q + CntW'(1);
        end else begin
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_REDUCE;
        end
      end

      // witness mod n, one bit a cycle
      ST_REDUCE: begin
        acc_d = rem_next;
        w_d   = w_q << 1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_last) begin
          if (rem_next == '0) begin
            prime_d = 1'b1;
            state_d = ST_DONE;
          end else begin
            base_d  = rem_next;
            x_d     = WIDTH'(1);
            state_d = ST_POW;
          end
        end
      end

      // square-and-multiply over the exponent bits
      ST_POW: begin
        acc_d = '0;
        cnt_d = '0;
        if (d_q == '0) begin
          state_d = ST_CHECK;
        end else if (d_q[0]) begin
          op_d    = OP_RES;
          mb_d    = base_q;
          state_d = ST_MUL;
        end else begin
          op_d    = OP_BASE;
          mb_d    = base_q;
          state_d = ST_MUL;
        end
      end

      // one multiplier bit a cycle, MSB first
      ST_MUL: begin
        acc_d = mul_next;
        mb_d  = mb_q << 1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_last) begin
          acc_d = '0;
          cnt_d = '0;
          unique case (op_q)
            OP_RES: begin
              x_d  = mul_next;
              op_d = OP_BASE;
              mb_d = base_q;
            end
            OP_BASE: begin
              base_d  = mul_next;
              d_d     = d_q >> 1;
              state_d = ST_POW;
            end
            OP_SQR: begin
              x_d     = mul_next;
              state_d = ST_SQTEST;
            end
            default: state_d = ST_POW;
          endcase
        end
      end

      ST_CHECK: begin
        if (x_is_one || x_is_nm1) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_SQCHK;
        end
      end

      // up to s-1 squarings
      ST_SQCHK: begin
        if (s_q > CntW'(1)) begin
          s_d     = s_q - CntW'(1);
          op_d    = OP_SQR;
          mb_d    = x_q;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_MUL;
        end else begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end
      end

      ST_SQTEST: begin
        priority if (x_is_one) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else if (x_is_nm1) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_SQCHK;
        end
      end

      // hand the word to the output register when it is free
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          pp_out_d    = prime_q;
          bad_out_d   = bad_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    w_q       <= w_d;
    d_q       <= d_d;
    x_q       <= x_d;
    base_q    <= base_d;
    acc_q     <= acc_d;
    mb_q      <= mb_d;
    cnt_q     <= cnt_d;
    s_q       <= s_d;
    op_q      <= op_d;
    prime_q   <= prime_d;
    bad_q     <= bad_d;
    pp_out_q  <= pp_out_d;
    bad_out_q <= bad_out_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign probable_prime_o = pp_out_q;
  assign bad_input_o      = bad_out_q;

endmodule
